// File: design/spifc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the SPI flash command sequencer.
// No dependencies; imported by every module of the block.
package spifc_pkg;

   // Input item codes
   localparam logic [2:0] CMD_READ       = 3'd0;
   localparam logic [2:0] CMD_PROGRAM    = 3'd1;
   localparam logic [2:0] CMD_ERASE_SEC  = 3'd2;
   localparam logic [2:0] CMD_ERASE_CHIP = 3'd3;
   localparam logic [2:0] CMD_READ_ID    = 3'd4;
   localparam logic [2:0] CMD_REPLY      = 3'd5;
   localparam logic [2:0] CMD_TICK       = 3'd6;

   // Flash opcodes
   localparam logic [7:0] OPC_WREN       = 8'h06;
   localparam logic [7:0] OPC_RDSR       = 8'h05;
   localparam logic [7:0] OPC_SECTOR_ERS = 8'h20;
   localparam logic [7:0] OPC_CHIP_ERS   = 8'hC7;
   localparam logic [7:0] OPC_PROGRAM    = 8'h02;
   localparam logic [7:0] OPC_READ       = 8'h03;
   localparam logic [7:0] OPC_JEDEC_ID   = 8'h9F;
   localparam logic [7:0] DUMMY_BYTE     = 8'h00;

   // JEDEC ID decode
   localparam logic [7:0]  MAKER_CODE       = 8'hEF;
   localparam logic [7:0]  SIZE_CODE_MIN    = 8'h15;
   localparam logic [7:0]  SIZE_CODE_MAX    = 8'h20;
   localparam logic [31:0] DEFAULT_CAPACITY = 32'd2097152;

   // Result status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_TIMEOUT  = 2'd1;
   localparam logic [1:0] STATUS_REJECTED = 2'd2;

   // Result kinds
   localparam logic RESULT_SPI_BYTE = 1'b0;
   localparam logic RESULT_FINISH   = 1'b1;

   // Register file
   localparam int          CSR_ADDR_W        = 3;
   localparam logic        CSR_IDX_TIMEOUT   = 1'b0;
   localparam logic [15:0] TIMEOUT_RESET     = 16'd5000;

   // Job queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   typedef enum logic [2:0] {
      JOB_READ       = 3'd0,
      JOB_PROGRAM    = 3'd1,
      JOB_ERASE_SEC  = 3'd2,
      JOB_ERASE_CHIP = 3'd3,
      JOB_READ_ID    = 3'd4,
      JOB_POLL       = 3'd5,
      JOB_FINISH     = 3'd6
   } job_op_type;

   typedef struct packed {
      job_op_type  op;
      logic [23:0] address;
      logic [7:0]  data;       // program data, or read data for a finish job
      logic [1:0]  status;
      logic [31:0] capacity;
   } job_type;

endpackage

// File: design/spifc_front.sv
`timescale 1ns / 1ps
// Front end: accepts input items, tracks the operation phase and poll timer,
// holds the timeout register, and posts one job per item that causes results.
// Depends on spifc_pkg.
module spifc_front
   import spifc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [2:0]            req_cmd,
   input  logic [23:0]           req_address,
   input  logic [7:0]            req_write_data,
   input  logic [7:0]            req_reply_byte,
   input  logic                  q_full,
   output logic                  job_push,
   output job_type               job,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata
);

   typedef enum logic [4:0] {
      PH_IDLE       = 5'b00001,
      PH_READ_REPLY = 5'b00010,
      PH_ID_REPLY   = 5'b00100,
      PH_POLL_REPLY = 5'b01000,
      PH_POLL_WAIT  = 5'b10000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [15:0] elapsed_ff, elapsed_in;
   logic [1:0]  id_count_ff, id_count_in;
   logic [7:0]  maker_ff, maker_in;
   logic [15:0] timeout_ff;
   logic        accept;
   logic        job_valid;
   logic [3:0]  size_shift;

   assign accept   = push && !q_full;
   assign job_push = accept && job_valid;
   assign prdata   = (paddr[2] == CSR_IDX_TIMEOUT) ? {16'd0, timeout_ff} : 32'd0;

   always_comb begin
      size_shift = 4'(req_reply_byte - SIZE_CODE_MIN);
      phase_in     = phase_ff;
      elapsed_in   = elapsed_ff;
      id_count_in  = id_count_ff;
      maker_in     = maker_ff;
      job_valid    = 1'b0;
      job.op       = JOB_FINISH;
      job.address  = req_address;
      job.data     = req_write_data;
      job.status   = STATUS_OK;
      job.capacity = 32'd0;
      if (accept) begin
         if (req_cmd <= CMD_READ_ID && phase_ff != PH_IDLE) begin
            job_valid  = 1'b1;
            job.data   = 8'd0;
            job.status = STATUS_REJECTED;
         end else begin
            case (req_cmd)
               CMD_READ: begin
                  job_valid = 1'b1;
                  job.op    = JOB_READ;
                  phase_in  = PH_READ_REPLY;
               end
               CMD_PROGRAM, CMD_ERASE_SEC, CMD_ERASE_CHIP: begin
                  job_valid  = 1'b1;
                  job.op     = (req_cmd == CMD_PROGRAM)   ? JOB_PROGRAM :
                               (req_cmd == CMD_ERASE_SEC) ? JOB_ERASE_SEC : JOB_ERASE_CHIP;
                  elapsed_in = 16'd0;
                  phase_in   = PH_POLL_REPLY;
               end
               CMD_READ_ID: begin
                  job_valid   = 1'b1;
                  job.op      = JOB_READ_ID;
                  id_count_in = 2'd0;
                  phase_in    = PH_ID_REPLY;
               end
               CMD_REPLY: begin
                  job.data = 8'd0;
                  case (phase_ff)
                     PH_READ_REPLY: begin
                        job_valid = 1'b1;
                        job.data  = req_reply_byte;
                        phase_in  = PH_IDLE;
                     end
                     PH_ID_REPLY: begin
                        if (id_count_ff == 2'd0) begin
                           maker_in = req_reply_byte;
                        end
                        if (id_count_ff >= 2'd2) begin
                           job_valid = 1'b1;
                           // code 0x20 shifts the size out to zero; codes outside the table give the default
                           if (maker_ff == MAKER_CODE && req_reply_byte >= SIZE_CODE_MIN
                               && req_reply_byte <= SIZE_CODE_MAX) begin
                              job.capacity = DEFAULT_CAPACITY << size_shift;
                           end else begin
                              job.capacity = DEFAULT_CAPACITY;
                           end
                           id_count_in = 2'd0;
                           phase_in    = PH_IDLE;
                        end else begin
                           id_count_in = id_count_ff + 2'd1;
                        end
                     end
                     PH_POLL_REPLY: begin
                        if (!req_reply_byte[0]) begin
                           job_valid = 1'b1;
                           phase_in  = PH_IDLE;
                        end else if (elapsed_ff > timeout_ff) begin
                           job_valid  = 1'b1;
                           job.status = STATUS_TIMEOUT;
                           phase_in   = PH_IDLE;
                        end else begin
                           phase_in = PH_POLL_WAIT;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
               CMD_TICK: begin
                  if (phase_ff == PH_POLL_REPLY || phase_ff == PH_POLL_WAIT) begin
                     if (elapsed_ff != 16'hFFFF) begin
                        elapsed_in = elapsed_ff + 16'd1;
                     end
                     if (phase_ff == PH_POLL_WAIT) begin
                        job_valid = 1'b1;
                        job.op    = JOB_POLL;
                        phase_in  = PH_POLL_REPLY;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         elapsed_ff  <= 16'd0;
         id_count_ff <= 2'd0;
         maker_ff    <= 8'd0;
         timeout_ff  <= TIMEOUT_RESET;
      end else begin
         phase_ff    <= phase_in;
         elapsed_ff  <= elapsed_in;
         id_count_ff <= id_count_in;
         maker_ff    <= maker_in;
         if (psel && penable && pwrite && paddr[2] == CSR_IDX_TIMEOUT) begin
            timeout_ff <= pwdata[15:0];
         end
      end
   end

endmodule

// File: design/spifc_job_queue.sv
`timescale 1ns / 1ps
// Short job queue that decouples the front end from the byte sequencer.
// Depends on spifc_pkg.
module spifc_job_queue
   import spifc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    q_push,
   input  job_type q_din,
   input  logic    q_pop,
   output job_type q_head,
   output logic    q_full,
   output logic    q_empty
);

   job_type                entries [QUEUE_DEPTH];
   logic [QUEUE_PTR_W:0]   wr_ptr_ff, rd_ptr_ff;

   assign q_empty = (wr_ptr_ff == rd_ptr_ff);
   assign q_full  = (wr_ptr_ff[QUEUE_PTR_W] != rd_ptr_ff[QUEUE_PTR_W]) &&
                    (wr_ptr_ff[QUEUE_PTR_W-1:0] == rd_ptr_ff[QUEUE_PTR_W-1:0]);
   assign q_head  = entries[rd_ptr_ff[QUEUE_PTR_W-1:0]];

   always_ff @(posedge clock) begin
      if (q_push) begin
         entries[wr_ptr_ff[QUEUE_PTR_W-1:0]] <= q_din;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         if (q_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (q_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !q_push)
      else $error("job queue written while full");
`endif

endmodule

// File: design/spifc_back.sv
`timescale 1ns / 1ps
// Back end: expands each job into its SPI bytes or finish result, into the
// result register one per cycle while it is free or popped. Depends on spifc_pkg.
module spifc_back
   import spifc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  job_type     q_head,
   input  logic        q_empty,
   output logic        q_pop,
   input  logic        pop,
   output logic        empty,
   output logic        rsp_kind,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_frame_end,
   output logic        rsp_reply_wanted,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_read_data,
   output logic [31:0] rsp_capacity_bytes,
   output logic        rsp_last
);

   typedef struct packed {
      logic [7:0] tx;
      logic       fe;
      logic       rw;
      logic       last;
   } entry_type;

   job_type    cur_ff, cur_in;
   logic       cur_valid_ff, cur_valid_in;
   logic [2:0] step_ff, step_in;
   logic       out_valid_ff;
   entry_type  ent;
   logic       advance, emit, done;

   function automatic entry_type seq_entry(job_type j, logic [2:0] s);
      entry_type e;
      e = '{tx: DUMMY_BYTE, fe: 1'b0, rw: 1'b0, last: 1'b0};
      case (j.op)
         JOB_READ: begin
            case (s)
               3'd0: e.tx = OPC_READ;
               3'd1: e.tx = j.address[23:16];
               3'd2: e.tx = j.address[15:8];
               3'd3: e.tx = j.address[7:0];
               default: e = '{tx: DUMMY_BYTE, fe: 1'b1, rw: 1'b1, last: 1'b1};
            endcase
         end
         JOB_PROGRAM: begin
            case (s)
               3'd0: e = '{tx: OPC_WREN, fe: 1'b1, rw: 1'b0, last: 1'b0};
               3'd1: e.tx = OPC_PROGRAM;
               3'd2: e.tx = j.address[23:16];
               3'd3: e.tx = j.address[15:8];
               3'd4: e.tx = j.address[7:0];
               3'd5: e = '{tx: j.data, fe: 1'b1, rw: 1'b0, last: 1'b0};
               3'd6: e.tx = OPC_RDSR;
               default: e = '{tx: DUMMY_BYTE, fe: 1'b1, rw: 1'b1, last: 1'b1};
            endcase
         end
         JOB_ERASE_SEC: begin
            case (s)
               3'd0: e = '{tx: OPC_WREN, fe: 1'b1, rw: 1'b0, last: 1'b0};
               3'd1: e.tx = OPC_SECTOR_ERS;
               3'd2: e.tx = j.address[23:16];
               3'd3: e.tx = j.address[15:8];
               3'd4: e = '{tx: j.address[7:0], fe: 1'b1, rw: 1'b0, last: 1'b0};
               3'd5: e.tx = OPC_RDSR;
               default: e = '{tx: DUMMY_BYTE, fe: 1'b1, rw: 1'b1, last: 1'b1};
            endcase
         end
         JOB_ERASE_CHIP: begin
            case (s)
               3'd0: e = '{tx: OPC_WREN, fe: 1'b1, rw: 1'b0, last: 1'b0};
               3'd1: e = '{tx: OPC_CHIP_ERS, fe: 1'b1, rw: 1'b0, last: 1'b0};
               3'd2: e.tx = OPC_RDSR;
               default: e = '{tx: DUMMY_BYTE, fe: 1'b1, rw: 1'b1, last: 1'b1};
            endcase
         end
         JOB_READ_ID: begin
            case (s)
               3'd0: e.tx = OPC_JEDEC_ID;
               3'd1: e.rw = 1'b1;
               3'd2: e.rw = 1'b1;
               default: e = '{tx: DUMMY_BYTE, fe: 1'b1, rw: 1'b1, last: 1'b1};
            endcase
         end
         JOB_POLL: begin
            case (s)
               3'd0: e.tx = OPC_RDSR;
               default: e = '{tx: DUMMY_BYTE, fe: 1'b1, rw: 1'b1, last: 1'b1};
            endcase
         end
         default: e.last = 1'b1;
      endcase
      return e;
   endfunction

   assign ent     = seq_entry(cur_ff, step_ff);
   assign advance = !out_valid_ff || pop;
   assign emit    = cur_valid_ff && advance;
   assign done    = emit && ent.last;
   assign q_pop   = !q_empty && (!cur_valid_ff || done);
   assign empty   = !out_valid_ff;

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      step_in      = step_ff;
      if (q_pop) begin
         cur_in       = q_head;
         cur_valid_in = 1'b1;
         step_in      = 3'd0;
      end else if (done) begin
         cur_valid_in = 1'b0;
      end else if (emit) begin
         step_in = step_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         step_ff      <= 3'd0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         step_ff      <= step_in;
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // result payload: load on emit, otherwise hold
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (emit) begin
         rsp_last <= ent.last;
         if (cur_ff.op == JOB_FINISH) begin
            rsp_kind           <= RESULT_FINISH;
            rsp_tx_byte        <= 8'd0;
            rsp_frame_end      <= 1'b0;
            rsp_reply_wanted   <= 1'b0;
            rsp_status         <= cur_ff.status;
            rsp_read_data      <= cur_ff.data;
            rsp_capacity_bytes <= cur_ff.capacity;
         end else begin
            rsp_kind           <= RESULT_SPI_BYTE;
            rsp_tx_byte        <= ent.tx;
            rsp_frame_end      <= ent.fe;
            rsp_reply_wanted   <= ent.rw;
            rsp_status         <= STATUS_OK;
            rsp_read_data      <= 8'd0;
            rsp_capacity_bytes <= 32'd0;
         end
      end
   end

`ifndef SYNTHESIS
   a_finish_is_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_kind == RESULT_FINISH) |-> rsp_last)
      else $error("finish result not marked last");
   a_byte_has_no_status: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_kind == RESULT_SPI_BYTE) |->
         (rsp_status == STATUS_OK && rsp_capacity_bytes == 32'd0))
      else $error("spi byte result carries finish fields");
   a_job_runs_on: assert property (@(posedge clock) disable iff (reset)
      (cur_valid_ff && !done) |=> cur_valid_ff)
      else $error("job dropped before its last result");
`endif

endmodule

// File: design/spi_flash_command_sequencer.sv
`timescale 1ns / 1ps
// SPI flash command sequencer top level. Operations, flash replies and 1 ms
// ticks enter as queue items; each accepted item is classified as it is
// taken, and its SPI bytes or finish result leave one per cycle while the
// result register is free or popped (up to eight bytes for a program, one
// for a finish, none for an ignored reply or tick); the result sequencer sets
// that rate, and a four-deep job queue lets input be taken while it works.
// Depends on spifc_pkg, spifc_front, spifc_job_queue and spifc_back.
module spi_flash_command_sequencer
   import spifc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  logic [2:0]            req_cmd,
   input  logic [23:0]           req_address,
   input  logic [7:0]            req_write_data,
   input  logic [7:0]            req_reply_byte,
   output logic                  empty,
   input  logic                  pop,
   output logic                  rsp_kind,
   output logic [7:0]            rsp_tx_byte,
   output logic                  rsp_frame_end,
   output logic                  rsp_reply_wanted,
   output logic [1:0]            rsp_status,
   output logic [7:0]            rsp_read_data,
   output logic [31:0]           rsp_capacity_bytes,
   output logic                  rsp_last,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   job_type job, q_head;
   logic    job_push, q_pop, q_full, q_empty;

   assign full   = q_full;
   assign pready = 1'b1;

   spifc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .req_cmd        (req_cmd),
      .req_address    (req_address),
      .req_write_data (req_write_data),
      .req_reply_byte (req_reply_byte),
      .q_full         (q_full),
      .job_push       (job_push),
      .job            (job),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata)
   );

   spifc_job_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (job_push),
      .q_din   (job),
      .q_pop   (q_pop),
      .q_head  (q_head),
      .q_full  (q_full),
      .q_empty (q_empty)
   );

   spifc_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_head             (q_head),
      .q_empty            (q_empty),
      .q_pop              (q_pop),
      .pop                (pop),
      .empty              (empty),
      .rsp_kind           (rsp_kind),
      .rsp_tx_byte        (rsp_tx_byte),
      .rsp_frame_end      (rsp_frame_end),
      .rsp_reply_wanted   (rsp_reply_wanted),
      .rsp_status         (rsp_status),
      .rsp_read_data      (rsp_read_data),
      .rsp_capacity_bytes (rsp_capacity_bytes),
      .rsp_last           (rsp_last)
   );

endmodule
